### hdl/fca_pkg.sv
`timescale 1ns / 1ps

package fca_pkg;

	localparam int OP_W     = 2;
	localparam int INDEX_W  = 12;
	localparam int VALUE_W  = 32;
	localparam int LIMIT_W  = 13;
	localparam int CURSOR_W = 12;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_EXTEND = 2'd3
	} op_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	localparam logic [LIMIT_W-1:0]  FIRST_CLUSTER = 13'd2;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 13'd4096;
	localparam logic [CURSOR_W-1:0] CURSOR_RESET  = 12'd2;
	localparam logic [VALUE_W-1:0]  END_OF_CHAIN  = 32'hFFFF_FFFF;

	// Status flags from the sequencer to the top level.
	typedef struct packed {
		logic clearing;
		logic scanning;
	} ctrl_status_t;

endpackage

### hdl/fca_if.sv
`timescale 1ns / 1ps

interface fca_req_if;
	logic                           valid;
	logic                           ready;
	logic [fca_pkg::OP_W-1:0]       operation;
	logic [fca_pkg::INDEX_W-1:0]    entry_index;
	logic [fca_pkg::VALUE_W-1:0]    entry_value;

	modport source (output valid, output operation, output entry_index, output entry_value,
		input ready);
	modport sink (input valid, input operation, input entry_index, input entry_value,
		output ready);
endinterface

interface fca_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fca_pkg::VALUE_W-1:0]    result_value;
	logic                           status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

### hdl/fat_cluster_allocator.sv
`timescale 1ns / 1ps

// FAT cluster allocator with next-fit search. The table lives in one synchronous RAM of
// TABLE_DEPTH 32-bit entries with a single read and a single write port, and the
// allocation cursor sits in a register beside it. After reset the block sweeps the RAM to
// zero, one entry per cycle, and no request transfer is taken until the sweep is done;
// the cluster_limit register can be written during that sweep. Requests are served
// one at a time and a finished result waits in an output register, so the next request can
// transfer while the previous result is still unclaimed. A write passes through the deliver
// state to the output register, a read through a read state first. An allocate examines
// entries until a free one is found and then marks it, and an extend with a valid tail first
// writes the link; the scan runs at one entry per cycle, bounded by the single RAM read
// port. When no free entry exists the result comes after all limit - 2 candidates have
// been examined, and without a search when the limit leaves no cluster.
// A full table reports status 1 with result 0xFFFFFFFF and changes nothing.
module fat_cluster_allocator #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fca_req_if.sink                       req,
	fca_rsp_if.source                     rsp,
	input  logic                          cfg_write,
	input  logic [fca_pkg::LIMIT_W-1:0]   cfg_data
);
	import fca_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [LIMIT_W-1:0]  cluster_limit_q;
	logic [LIMIT_W-1:0]  lim_eff;

	logic                mem_rd_en;
	logic [AW-1:0]       mem_rd_addr;
	logic [VALUE_W-1:0]  mem_rd_data;
	logic                mem_wr_en;
	logic [AW-1:0]       mem_wr_addr;
	logic [VALUE_W-1:0]  mem_wr_data;
	ctrl_status_t        ctrl_status;

	// The limit register must be written only while no request is in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			cluster_limit_q <= cfg_data;
		end
	end

	// The search never runs past the end of the table, whatever the register holds.
	assign lim_eff = (32'(cluster_limit_q) > TABLE_DEPTH) ? LIMIT_W'(TABLE_DEPTH)
		: cluster_limit_q;

	fca_fat_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	fca_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.limit       (lim_eff),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.status      (ctrl_status)
	);

	// No request may transfer while the table is still being cleared.
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_status.clearing |-> !req.ready)
		else $error("request ready during table clear");

	// No request may transfer while a search is running.
	a_no_req_while_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_status.scanning |-> !req.ready)
		else $error("request ready during search");

	// Requests are served one at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in flight");

	// A full report always carries the end-of-chain value.
	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.result_value == END_OF_CHAIN))
		else $error("full status without all-ones result");

endmodule

### hdl/fca_fat_ram.sv
`timescale 1ns / 1ps

module fca_fat_ram #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [fca_pkg::VALUE_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [fca_pkg::VALUE_W-1:0]   rd_data
);
	import fca_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/fca_ctrl.sv
`timescale 1ns / 1ps

module fca_ctrl #(
	parameter int TABLE_DEPTH = 4096,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fca_req_if.sink                       req,
	fca_rsp_if.source                     rsp,
	input  logic [fca_pkg::LIMIT_W-1:0]   limit,
	output logic                          mem_rd_en,
	output logic [AW-1:0]                 mem_rd_addr,
	input  logic [fca_pkg::VALUE_W-1:0]   mem_rd_data,
	output logic                          mem_wr_en,
	output logic [AW-1:0]                 mem_wr_addr,
	output logic [fca_pkg::VALUE_W-1:0]   mem_wr_data,
	output fca_pkg::ctrl_status_t         status
);
	import fca_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCAN,
		S_LINK,
		S_MARK,
		S_DELIVER
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [INDEX_W-1:0]   idx_q;
	logic                 idx_ok_q;
	logic [CURSOR_W-1:0]  cursor_q;
	logic [AW-1:0]        clr_addr_q;
	logic [LIMIT_W-1:0]   scan_c_q;
	logic [LIMIT_W-1:0]   issued_q;
	logic [LIMIT_W-1:0]   total_q;
	logic                 pend_valid_s1;
	logic                 pend_last_s1;
	logic [LIMIT_W-1:0]   pend_c_s1;
	logic [LIMIT_W-1:0]   found_q;
	logic [VALUE_W-1:0]   res_value_q;
	logic                 res_status_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic                 out_status_q;

	logic                 accept;
	op_t                  req_op;
	logic                 req_idx_ok;
	logic [LIMIT_W-1:0]   cur_ext;
	logic [LIMIT_W-1:0]   start;
	logic [LIMIT_W-1:0]   lim_last;
	logic                 issue;
	logic                 hit;
	logic                 out_free;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign req_op     = op_t'(req.operation);
	assign req_idx_ok = (32'(req.entry_index) < TABLE_DEPTH);

	// The next-fit start falls back to the first cluster when the cursor is out of range.
	assign cur_ext  = LIMIT_W'(cursor_q);
	assign start    = (cur_ext >= FIRST_CLUSTER && cur_ext < limit) ? cur_ext : FIRST_CLUSTER;
	assign lim_last = limit - LIMIT_W'(1);

	assign issue    = (state_q == S_SCAN) && (issued_q != total_q);
	assign hit      = pend_valid_s1 && (mem_rd_data == '0);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(req.entry_index);
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(req.entry_index);
		mem_wr_data = req.entry_value;
		unique case (state_q)
			S_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_addr_q;
				mem_wr_data = '0;
			end
			S_IDLE: begin
				mem_rd_en = accept && (req_op == OP_READ) && req_idx_ok;
				mem_wr_en = accept && (req_op == OP_WRITE) && req_idx_ok;
			end
			S_SCAN: begin
				mem_rd_en   = issue;
				mem_rd_addr = AW'(scan_c_q);
			end
			S_LINK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = AW'(idx_q);
				mem_wr_data = VALUE_W'(found_q);
			end
			S_MARK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = AW'(found_q);
				mem_wr_data = END_OF_CHAIN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			cursor_q      <= CURSOR_RESET;
			pend_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q          <= req_op;
						idx_q         <= req.entry_index;
						idx_ok_q      <= req_idx_ok;
						pend_valid_s1 <= 1'b0;
						scan_c_q      <= start;
						issued_q      <= '0;
						total_q       <= limit - FIRST_CLUSTER;
						unique case (req_op) inside
							OP_READ: begin
								state_q <= S_READ;
							end
							OP_WRITE: begin
								res_value_q  <= '0;
								res_status_q <= ST_OK;
								state_q      <= S_DELIVER;
							end
							OP_ALLOC, OP_EXTEND: begin
								if (limit <= FIRST_CLUSTER) begin
									res_value_q  <= END_OF_CHAIN;
									res_status_q <= ST_FULL;
									state_q      <= S_DELIVER;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					res_value_q  <= idx_ok_q ? mem_rd_data : '0;
					res_status_q <= ST_OK;
					state_q      <= S_DELIVER;
				end
				S_SCAN: begin
					// Reads are issued one a cycle; each is checked when its data returns.
					// After the last read has been issued nothing more is issued.
					if (issue) begin
						scan_c_q <= (scan_c_q == lim_last) ? FIRST_CLUSTER
							: scan_c_q + LIMIT_W'(1);
						issued_q <= issued_q + LIMIT_W'(1);
					end
					pend_valid_s1 <= issue && !hit;
					pend_c_s1     <= scan_c_q;
					pend_last_s1  <= (issued_q == total_q - LIMIT_W'(1));
					if (hit) begin
						found_q <= pend_c_s1;
						state_q <= (op_q == OP_EXTEND && idx_ok_q) ? S_LINK : S_MARK;
					end else if (pend_valid_s1 && pend_last_s1) begin
						res_value_q  <= END_OF_CHAIN;
						res_status_q <= ST_FULL;
						state_q      <= S_DELIVER;
					end
				end
				S_LINK: begin
					state_q <= S_MARK;
				end
				S_MARK: begin
					cursor_q     <= CURSOR_W'(found_q + LIMIT_W'(1));
					res_value_q  <= VALUE_W'(found_q);
					res_status_q <= ST_OK;
					state_q      <= S_DELIVER;
				end
				S_DELIVER: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_DELIVER && out_free) begin
				out_valid_q  <= 1'b1;
				out_value_q  <= res_value_q;
				out_status_q <= res_status_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;

	assign status.clearing = (state_q == S_CLEAR);
	assign status.scanning = (state_q == S_SCAN);

endmodule
